// ----- rtl/fta_pkg.sv -----
// Shared types, codes and helpers for the frame traffic accounting block.
package fta_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CLS_IPV4  = 2'd0,
    CLS_IPV6  = 2'd1,
    CLS_ARP   = 2'd2,
    CLS_OTHER = 2'd3
  } frame_cls_e;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2
  } cnt_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } seq_state_e;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] MIN_FRAME  = 16'd60;
  localparam logic [6:0]  UDP_HDR    = 7'd8;
  localparam logic [4:0]  SEL_MAX    = 5'd26;
  localparam logic [1:0]  SEL_ALL    = 2'd2;

  typedef struct packed {
    logic       tx;
    logic       srv;
    frame_cls_e cls;
    logic [16:0] wire_cnt;
    logic [15:0] payload;
  } frame_sum_t;

  typedef struct packed {
    logic        valid;
    cnt_op_e     op;
    logic [1:0]  row;
    logic [16:0] wire_cnt;
    logic [15:0] payload;
    logic [4:0]  sel;
  } cnt_req_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] metric;
    logic [1:0] dir;
    logic [1:0] cls;
  } sel_dec_t;

  // Result fields in the order of the result channel.
  typedef struct packed {
    logic        kind;
    logic [63:0] value;
    logic        tx;
    logic        srv;
    logic [1:0]  cls;
    logic [16:0] wire_cnt;
    logic [15:0] payload;
  } result_t;

  // Split metric*9 + direction*3 + class into its digits.
  function automatic sel_dec_t decode_sel(input logic [4:0] sel);
    sel_dec_t d;
    logic [4:0] rem;
    d.ok     = (sel <= SEL_MAX);
    d.metric = (sel >= 5'd18) ? 2'd2 : ((sel >= 5'd9) ? 2'd1 : 2'd0);
    rem      = sel - ((d.metric == 2'd2) ? 5'd18 : ((d.metric == 2'd1) ? 5'd9 : 5'd0));
    d.dir    = (rem >= 5'd6) ? 2'd2 : ((rem >= 5'd3) ? 2'd1 : 2'd0);
    rem      = rem - ((d.dir == 2'd2) ? 5'd6 : ((d.dir == 2'd1) ? 5'd3 : 5'd0));
    d.cls    = rem[1:0];
    return d;
  endfunction

endpackage

// ----- rtl/fta_if.sv -----
// Request and result channel interfaces.
interface fta_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] frame_length;
  logic [4:0]  counter_select;
  modport source (output valid, command, data_byte, last_byte, frame_length,
                  counter_select, input ready);
  modport sink (input valid, command, data_byte, last_byte, frame_length,
                counter_select, output ready);
endinterface

interface fta_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [63:0] counter_value;
  logic        is_transmit;
  logic        is_server;
  logic [1:0]  frame_class;
  logic [16:0] wire_bytes;
  logic [15:0] payload_bytes;
  modport source (output valid, result_kind, counter_value, is_transmit, is_server,
                  frame_class, wire_bytes, payload_bytes, input ready);
  modport sink (input valid, result_kind, counter_value, is_transmit, is_server,
                frame_class, wire_bytes, payload_bytes, output ready);
endinterface

// ----- rtl/frame_traffic_accounting.sv -----
// Top level of the frame traffic accounting block.
// Frame bytes are taken one per clock with no gaps while the request channel is ready,
// including the last byte of a frame, whose summary goes to the output register, or to the
// spare register while the output is stalled; the counter update runs behind it in a
// read-modify-write on a four-row counter memory with forwarding. A clear empties all rows.
// A counter read walks the four memory rows through the single read port: the request
// channel is held off until the last row is summed, then the sum goes out as a result.
// A spare register takes a result that meets a stalled output, so requests keep flowing while
// one result waits; the request channel stalls only while the spare is full or a read runs.
module frame_traffic_accounting #(
  parameter int COUNTER_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  fta_in_if.sink       in_ch,
  fta_out_if.source    out_ch,
  input  logic         cfg_write,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [31:0] local_address;
  logic [31:0] server_address;

  logic accept, take, frame_done, out_free, cnt_busy, rd_done;
  logic [COUNTER_WIDTH-1:0] rd_value;
  fta_pkg::frame_sum_t sum;
  fta_pkg::cnt_req_t   req;
  logic [1:0]          row;

  logic                res_valid;
  logic                skid_valid;
  fta_pkg::result_t    res;
  fta_pkg::result_t    skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address  <= '0;
      server_address <= '1;
    end else if (cfg_write) begin
      if (cfg_index == 1'b0) begin
        local_address <= cfg_data;
      end else begin
        server_address <= cfg_data;
      end
    end
  end

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = !skid_valid && !cnt_busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign take        = accept && in_ch.command == fta_pkg::CMD_BYTE;
  assign frame_done  = take && in_ch.last_byte;

  fta_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .data_byte      (in_ch.data_byte),
    .last_byte      (in_ch.last_byte),
    .frame_length   (in_ch.frame_length),
    .local_address  (local_address),
    .server_address (server_address),
    .sum            (sum),
    .row            (row)
  );

  always_comb begin
    req.valid    = frame_done
                   || (accept && in_ch.command == fta_pkg::CMD_READ)
                   || (accept && in_ch.command == fta_pkg::CMD_CLEAR);
    req.op       = frame_done ? fta_pkg::OP_UPDATE
                 : ((in_ch.command == fta_pkg::CMD_READ) ? fta_pkg::OP_READ : fta_pkg::OP_CLEAR);
    req.row      = row;
    req.wire_cnt = sum.wire_cnt;
    req.payload  = sum.payload;
    req.sel      = in_ch.counter_select;
  end

  fta_counters #(
    .CW (COUNTER_WIDTH)
  ) u_counters (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .busy     (cnt_busy),
    .rd_done  (rd_done),
    .rd_value (rd_value)
  );

  assign res_valid = frame_done || rd_done;

  always_comb begin
    res = '0;
    if (frame_done) begin
      res.tx       = sum.tx;
      res.srv      = sum.srv;
      res.cls      = sum.cls;
      res.wire_cnt = sum.wire_cnt;
      res.payload  = sum.payload;
    end else begin
      res.kind  = 1'b1;
      res.value = 64'(rd_value);
    end
  end

  // Park a result in the spare register while the output is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      out_ch.valid <= skid_valid || res_valid;
      skid_valid   <= skid_valid && res_valid;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        {out_ch.result_kind, out_ch.counter_value, out_ch.is_transmit, out_ch.is_server,
         out_ch.frame_class, out_ch.wire_bytes, out_ch.payload_bytes} <= skid;
      end else if (res_valid) begin
        {out_ch.result_kind, out_ch.counter_value, out_ch.is_transmit, out_ch.is_server,
         out_ch.frame_class, out_ch.wire_bytes, out_ch.payload_bytes} <= res;
      end
    end
    if (res_valid && (skid_valid || !out_free)) skid <= res;
  end

endmodule

// ----- rtl/fta_parser.sv -----
// Byte-wise frame header parser and frame classifier.
module fta_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic [15:0]        frame_length,
  input  logic [31:0]        local_address,
  input  logic [31:0]        server_address,
  output fta_pkg::frame_sum_t sum,
  output logic [1:0]         row
);

  logic [15:0] byte_position, byte_position_next;
  logic [15:0] ether_kind, ether_kind_next;
  logic [3:0]  ip_header_words, ip_header_words_next;
  logic [7:0]  transport_protocol, transport_protocol_next;
  logic [15:0] ip_length_field, ip_length_field_next;
  logic [3:0]  tcp_header_words, tcp_header_words_next;
  logic [31:0] source_address, source_address_next;
  logic [31:0] dest_address, dest_address_next;

  logic [15:0] p;
  logic [15:0] tcp_pos;
  logic [31:0] src, dst;
  logic [6:0]  hdr;
  logic        l4;

  assign p       = byte_position;
  assign tcp_pos = 16'd26 + {10'd0, ip_header_words, 2'b00};

  always_comb begin
    byte_position_next      = (p == 16'hffff) ? p : p + 16'd1;
    ether_kind_next         = ether_kind;
    ip_header_words_next    = ip_header_words;
    transport_protocol_next = transport_protocol;
    ip_length_field_next    = ip_length_field;
    tcp_header_words_next   = tcp_header_words;
    source_address_next     = source_address;
    dest_address_next       = dest_address;
    if (p == 16'd12) begin
      ether_kind_next = {data_byte, 8'h00};
    end else if (p == 16'd13) begin
      ether_kind_next = ether_kind | {8'h00, data_byte};
    end
    if (p >= 16'd14) begin
      if (ether_kind == fta_pkg::ETYPE_IPV4) begin
        if (p == 16'd14) begin
          ip_header_words_next = data_byte[3:0];
        end else if (p == 16'd16) begin
          ip_length_field_next = {data_byte, 8'h00};
        end else if (p == 16'd17) begin
          ip_length_field_next = ip_length_field | {8'h00, data_byte};
        end else if (p == 16'd23) begin
          transport_protocol_next = data_byte;
        end
        if (p >= 16'd26 && p <= 16'd29) begin
          source_address_next = {source_address[23:0], data_byte};
        end
        if (p >= 16'd30 && p <= 16'd33) begin
          dest_address_next = {dest_address[23:0], data_byte};
        end
        if (p == tcp_pos) begin
          tcp_header_words_next = data_byte[7:4];
        end
      end else if (ether_kind == fta_pkg::ETYPE_IPV6) begin
        if (p == 16'd18) begin
          ip_length_field_next = {data_byte, 8'h00};
        end else if (p == 16'd19) begin
          ip_length_field_next = ip_length_field | {8'h00, data_byte};
        end else if (p == 16'd20) begin
          transport_protocol_next = data_byte;
        end else if (p == 16'd66) begin
          tcp_header_words_next = data_byte[7:4];
        end
      end else if (ether_kind == fta_pkg::ETYPE_ARP) begin
        if (p >= 16'd28 && p <= 16'd31) begin
          source_address_next = {source_address[23:0], data_byte};
        end
        if (p >= 16'd38 && p <= 16'd41) begin
          dest_address_next = {dest_address[23:0], data_byte};
        end
      end
    end
  end

  // Classify using the state as it stands after this byte.
  always_comb begin
    if (ether_kind_next == fta_pkg::ETYPE_IPV4) begin
      sum.cls = fta_pkg::CLS_IPV4;
    end else if (ether_kind_next == fta_pkg::ETYPE_IPV6) begin
      sum.cls = fta_pkg::CLS_IPV6;
    end else if (ether_kind_next == fta_pkg::ETYPE_ARP) begin
      sum.cls = fta_pkg::CLS_ARP;
    end else begin
      sum.cls = fta_pkg::CLS_OTHER;
    end
    if (sum.cls == fta_pkg::CLS_IPV4 || sum.cls == fta_pkg::CLS_ARP) begin
      src = source_address_next;
      dst = dest_address_next;
    end else begin
      src = '1;
      dst = '1;
    end
    hdr = (sum.cls == fta_pkg::CLS_IPV4) ? {1'b0, ip_header_words_next, 2'b00} : 7'd0;
    l4  = 1'b0;
    if (transport_protocol_next == fta_pkg::PROTO_TCP) begin
      hdr = hdr + {1'b0, tcp_header_words_next, 2'b00};
      l4  = 1'b1;
    end else if (transport_protocol_next == fta_pkg::PROTO_UDP) begin
      hdr = hdr + fta_pkg::UDP_HDR;
      l4  = 1'b1;
    end
    sum.payload = 16'd0;
    if ((sum.cls == fta_pkg::CLS_IPV4 || sum.cls == fta_pkg::CLS_IPV6) && l4
        && ip_length_field_next > {9'd0, hdr}) begin
      sum.payload = ip_length_field_next - {9'd0, hdr};
    end
    sum.tx = (src == local_address);
    if (sum.tx) begin
      sum.srv  = (dst == server_address);
      // pad short transmit frames up to the minimum
      sum.wire_cnt = (frame_length < fta_pkg::MIN_FRAME) ? 17'd64
                                                         : {1'b0, frame_length} + 17'd4;
    end else begin
      sum.srv  = (src == server_address) && (dst == local_address);
      sum.wire_cnt = {1'b0, frame_length} + 17'd4;
    end
    row = {~sum.tx, ~sum.srv};
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      byte_position      <= '0;
      ether_kind         <= '0;
      ip_header_words    <= '0;
      transport_protocol <= '0;
      ip_length_field    <= '0;
      tcp_header_words   <= '0;
      source_address     <= '0;
      dest_address       <= '0;
    end else if (take) begin
      byte_position      <= byte_position_next;
      ether_kind         <= ether_kind_next;
      ip_header_words    <= ip_header_words_next;
      transport_protocol <= transport_protocol_next;
      ip_length_field    <= ip_length_field_next;
      tcp_header_words   <= tcp_header_words_next;
      source_address     <= source_address_next;
      dest_address       <= dest_address_next;
    end
  end

endmodule

// ----- rtl/fta_counters.sv -----
// Counter store: one row per direction and server flag, read-modify-write and read-back sums.
module fta_counters #(
  parameter int CW = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  fta_pkg::cnt_req_t req,
  output logic             busy,
  output logic             rd_done,
  output logic [CW-1:0]    rd_value
);

  localparam int RW = 3 * CW;

  logic [RW-1:0] mem [4];
  logic [RW-1:0] rdata;
  logic [3:0]    row_valid;

  fta_pkg::seq_state_e state, state_next;
  logic [1:0]       rd_row;
  fta_pkg::sel_dec_t rd_dec;

  logic             issue_valid;
  fta_pkg::cnt_op_e issue_op;
  logic [1:0]       issue_row;
  logic             issue_last;

  logic             s1_valid;
  fta_pkg::cnt_op_e s1_op;
  logic [1:0]       s1_row;
  logic             s1_last;
  logic [16:0]      s1_wire;
  logic [15:0]      s1_payload;

  logic          fwd_valid;
  logic [1:0]    fwd_row;
  logic [RW-1:0] fwd_data;

  logic [RW-1:0] cur, upd;
  logic [CW-1:0] field, acc, acc_next;
  logic          row_hit;
  logic          wr;

  always_comb begin
    state_next = state;
    case (state)
      fta_pkg::ST_IDLE: begin
        if (req.valid && req.op == fta_pkg::OP_READ) state_next = fta_pkg::ST_READ;
      end
      fta_pkg::ST_READ: begin
        if (rd_row == 2'd3) state_next = fta_pkg::ST_IDLE;
      end
      default: state_next = fta_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    issue_valid = 1'b0;
    issue_op    = fta_pkg::OP_UPDATE;
    issue_row   = 2'd0;
    issue_last  = 1'b0;
    case (state)
      fta_pkg::ST_IDLE: begin
        issue_valid = req.valid;
        issue_op    = req.op;
        issue_row   = (req.op == fta_pkg::OP_READ) ? 2'd0 : req.row;
      end
      fta_pkg::ST_READ: begin
        issue_valid = 1'b1;
        issue_op    = fta_pkg::OP_READ;
        issue_row   = rd_row;
        issue_last  = (rd_row == 2'd3);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fta_pkg::ST_IDLE;
      rd_row   <= '0;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_row   <= (state == fta_pkg::ST_READ) ? rd_row + 2'd1 : 2'd1;
      s1_valid <= issue_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_op      <= issue_op;
    s1_row     <= issue_row;
    s1_last    <= issue_last;
    s1_wire    <= req.wire_cnt;
    s1_payload <= req.payload;
    if (state == fta_pkg::ST_IDLE && req.valid && req.op == fta_pkg::OP_READ) begin
      rd_dec <= fta_pkg::decode_sel(req.sel);
    end
  end

  // Take the latest write of a row over the memory, and a cleared row as zero.
  always_comb begin
    if (fwd_valid && fwd_row == s1_row) begin
      cur = fwd_data;
    end else if (row_valid[s1_row]) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
    upd = {cur[3*CW-1:2*CW] + CW'(s1_payload),
           cur[2*CW-1:CW] + CW'(s1_wire),
           cur[CW-1:0] + CW'(1)};
    case (rd_dec.metric)
      2'd0:    field = cur[CW-1:0];
      2'd1:    field = cur[2*CW-1:CW];
      default: field = cur[3*CW-1:2*CW];
    endcase
    row_hit  = rd_dec.ok
               && (rd_dec.dir == fta_pkg::SEL_ALL || rd_dec.dir == {1'b0, s1_row[1]})
               && (rd_dec.cls == fta_pkg::SEL_ALL || rd_dec.cls == {1'b0, s1_row[0]});
    acc_next = ((s1_row == 2'd0) ? '0 : acc) + (row_hit ? field : '0);
    wr       = s1_valid && s1_op == fta_pkg::OP_UPDATE;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[issue_row];
    if (wr) mem[s1_row] <= upd;
    if (s1_valid && s1_op == fta_pkg::OP_READ) acc <= acc_next;
    if (wr) begin
      fwd_row  <= s1_row;
      fwd_data <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (s1_valid && s1_op == fta_pkg::OP_CLEAR) begin
      row_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (wr) begin
      row_valid[s1_row] <= 1'b1;
      fwd_valid         <= 1'b1;
    end
  end

  assign busy     = (state == fta_pkg::ST_READ) || (s1_valid && s1_op == fta_pkg::OP_READ);
  assign rd_done  = s1_valid && s1_op == fta_pkg::OP_READ && s1_last;
  assign rd_value = acc_next;

endmodule

// ----- rtl/fta_checker.sv -----
// Port-level checks for the frame traffic accounting block, bound to the top level.
module fta_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  command,
  input logic        last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic        is_transmit,
  input logic        is_server,
  input logic [16:0] wire_bytes,
  input logic [15:0] payload_bytes
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_frame_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == fta_pkg::CMD_BYTE && last_byte
    |=> out_valid)
    else $error("frame summary missing");

  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && command == fta_pkg::CMD_READ |=> !in_ready)
    else $error("request taken during counter read");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == 1'b1
    |-> !is_transmit && !is_server && wire_bytes == 17'd0 && payload_bytes == 16'd0)
    else $error("counter read carries frame fields");

endmodule

bind frame_traffic_accounting fta_checker u_fta_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .command       (in_ch.command),
  .last_byte     (in_ch.last_byte),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .result_kind   (out_ch.result_kind),
  .is_transmit   (out_ch.is_transmit),
  .is_server     (out_ch.is_server),
  .wire_bytes    (out_ch.wire_bytes),
  .payload_bytes (out_ch.payload_bytes)
);
